// ----- rtl/c2cs_pkg.sv -----
// Shared constants and types for the sparse coordinate-to-compressed converter.
package c2cs_pkg;
	localparam int MaxEntries = 32;
	localparam int MaxDim     = 31;
	localparam int IdxW       = 5;
	localparam int AddrW      = $clog2(MaxEntries);
	localparam int CntW       = $clog2(MaxEntries + 1);
	localparam int PosW       = 6;
	localparam int ValW       = 64;
	localparam int CfgIdxW    = 2;

	localparam logic [CfgIdxW-1:0] CfgCompressColumns = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgNumRows         = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgNumCols         = 2'd2;

	localparam logic [1:0] StatusOk       = 2'd0;
	localparam logic [1:0] StatusRange    = 2'd1;
	localparam logic [1:0] StatusOverflow = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_EMIT_RD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [IdxW-1:0] major;
		logic [IdxW-1:0] minor;
		logic [ValW-1:0] value;
	} entry_t;

	typedef struct packed {
		logic [PosW-1:0] position;
		logic            entry_present;
		logic [IdxW-1:0] major_index;
		logic [IdxW-1:0] minor_index;
		logic [ValW-1:0] sorted_value;
		logic            pointer_present;
		logic [PosW-1:0] pointer_value;
		logic            run_last;
		logic [1:0]      status;
	} result_t;

	typedef struct packed {
		logic [IdxW-1:0] row_one_based;
		logic [IdxW-1:0] col_one_based;
		logic [ValW-1:0] entry_value;
		logic            batch_last;
	} item_t;

	typedef struct packed {
		logic [CfgIdxW-1:0] index;
		logic [IdxW-1:0]    data;
	} cfg_t;
endpackage

// ----- rtl/c2cs_if.sv -----
// Valid/ready channel interface carrying one word of a generic payload.
interface c2cs_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/c2cs_store.sv -----
// Entry store: synchronous memory with one write port and one registered read port.
module c2cs_store (
	input  logic                   clk,
	input  logic                   we,
	input  logic [c2cs_pkg::AddrW-1:0] waddr,
	input  c2cs_pkg::entry_t       wdata,
	input  logic [c2cs_pkg::AddrW-1:0] raddr,
	output c2cs_pkg::entry_t       rdata
);
	import c2cs_pkg::*;
	entry_t mem [MaxEntries];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/coordinate_to_compressed_sparse.sv -----
// Top level: sparse entry insertion sort in memory and compressed pointer output.
// Usage: in (sink) takes one word per entry: 1-based row, column, 64 value bits
// and batch_last. cfg takes register writes (0 compress_columns, 1 num_rows,
// 2 num_cols), which the user must make only while idle; the block does not check.
// out (source) gives one word per position after batch_last: sorted entry, pointer slot.
// Timing: an entry is placed by walking the store down from the top slot, one
// slot per cycle: each stored entry with a larger key moves up one slot, then
// the new entry is written. The first entry of a batch is written directly from
// idle, and out-of-range or overflow entries are dropped without a walk.
// Output: each position passes a store read state and a capture state, and the
// read waits until a held word is taken; pointers come from a per-major histogram
// in flip-flops, summed as positions advance, so no extra scan is needed.
// Reset clears the count, error flags, histogram and control registers; the store needs no clearing.
// When out stalls, the block holds the word and accepts nothing new.
module coordinate_to_compressed_sparse (
	input logic clk,
	input logic arst_n,
	c2cs_if.sink   in,
	c2cs_if.sink   cfg,
	c2cs_if.source out
);
	import c2cs_pkg::*;

	state_t state_q, state_d;
	logic            cc_q;
	logic [IdxW-1:0] nrows_q, ncols_q;
	logic [CntW-1:0] count_q;
	logic [1:0]      err_q;
	logic [CntW-1:0] hist_q [MaxDim + 1];
	entry_t          new_q;
	logic            last_q;
	logic [AddrW-1:0] ptr_q;     // slot held in rdata while shifting
	logic [PosW-1:0] pos_q, n_q;
	logic [PosW-1:0] acc_q;      // running pointer
	logic [IdxW-1:0] mdim_q;
	logic            place_q;    // new entry goes to slot 0 this cycle
	result_t         res_q;
	logic            out_v_q;

	logic            we;
	logic [AddrW-1:0] waddr, raddr;
	entry_t          wdata, rdata;

	c2cs_store u_store (.clk, .we, .waddr, .wdata, .raddr, .rdata);

	logic [IdxW-1:0] rdim, cdim, maj_in, min_in;
	logic            bad;
	assign rdim   = (nrows_q > IdxW'(MaxDim)) ? IdxW'(MaxDim) : nrows_q;
	assign cdim   = (ncols_q > IdxW'(MaxDim)) ? IdxW'(MaxDim) : ncols_q;
	assign bad    = (in.data.row_one_based == '0) || (in.data.row_one_based > rdim) ||
		(in.data.col_one_based == '0) || (in.data.col_one_based > cdim);
	assign maj_in = cc_q ? in.data.col_one_based - 1'b1 : in.data.row_one_based - 1'b1;
	assign min_in = cc_q ? in.data.row_one_based - 1'b1 : in.data.col_one_based - 1'b1;

	logic rd_greater;
	assign rd_greater = {rdata.major, rdata.minor} > {new_q.major, new_q.minor};

	assign in.ready  = (state_q == ST_IDLE) && !out_v_q;
	assign cfg.ready = 1'b1;
	assign out.valid = out_v_q;
	assign out.data  = res_q;

	logic in_acc;
	assign in_acc = in.valid && in.ready;

	logic [IdxW-1:0] mdim_now;
	assign mdim_now = cc_q ? cdim : rdim;

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = ptr_q;
		wdata = new_q;
		raddr = ptr_q;
		case (state_q)
			ST_IDLE: begin
				// top stored slot, compared first
				raddr = AddrW'(count_q - 1'b1);
				if (in_acc) begin
					if (bad || count_q >= CntW'(MaxEntries)) state_d = in.data.batch_last ?
						ST_EMIT_RD : ST_IDLE;
					else if (count_q == '0) begin
						we = 1'b1;
						waddr = '0;
						wdata = '{maj_in, min_in, in.data.entry_value};
						state_d = in.data.batch_last ? ST_EMIT_RD : ST_IDLE;
					end else state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				// rdata holds slot ptr_q; a larger key moves up, else the new entry lands
				raddr = ptr_q - 1'b1;
				we = 1'b1;
				if (place_q) begin
					waddr = '0;
					wdata = new_q;
					state_d = last_q ? ST_EMIT_RD : ST_IDLE;
				end else if (rd_greater) begin
					waddr = ptr_q + 1'b1;
					wdata = rdata;
				end else begin
					waddr = ptr_q + 1'b1;
					wdata = new_q;
					state_d = last_q ? ST_EMIT_RD : ST_IDLE;
				end
			end
			ST_EMIT_RD: begin
				raddr = AddrW'(pos_q);
				if (!out_v_q || out.ready) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				raddr = AddrW'(pos_q);
				state_d = (pos_q + 1'b1 == n_q) ? ST_IDLE : ST_EMIT_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	logic [CntW-1:0] hsum;
	always_comb begin
		hsum = '0;
		if (pos_q != '0 && pos_q <= PosW'(MaxDim) + 1'b1) hsum = hist_q[IdxW'(pos_q - 1'b1)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= 1'b0; nrows_q <= IdxW'(MaxDim); ncols_q <= IdxW'(MaxDim);
			count_q <= '0; err_q <= '0; out_v_q <= 1'b0; place_q <= 1'b0;
			ptr_q <= '0; pos_q <= '0; n_q <= '0; acc_q <= '0;
			mdim_q <= '0; last_q <= 1'b0;
			for (int i = 0; i <= MaxDim; i++) hist_q[i] <= '0;
		end else begin
			if (cfg.valid) begin
				if (cfg.data.index == CfgCompressColumns) cc_q <= cfg.data.data[0];
				else if (cfg.data.index == CfgNumRows) nrows_q <= cfg.data.data;
				else if (cfg.data.index == CfgNumCols) ncols_q <= cfg.data.data;
			end
			if (out_v_q && out.ready) out_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (in_acc) begin
					new_q <= '{maj_in, min_in, in.data.entry_value};
					last_q <= in.data.batch_last;
					ptr_q <= AddrW'(count_q - 1'b1);
					pos_q <= '0; acc_q <= '0; place_q <= 1'b0;
					if (bad) err_q[0] <= 1'b1;
					else if (count_q >= CntW'(MaxEntries)) err_q[1] <= 1'b1;
					else begin
						count_q <= count_q + 1'b1;
						hist_q[maj_in] <= hist_q[maj_in] + 1'b1;
					end
					if (in.data.batch_last) begin
						mdim_q <= mdim_now;
						n_q <= (PosW'(count_q) + ((bad || count_q >= CntW'(MaxEntries)) ?
							PosW'(0) : PosW'(1)) > PosW'(mdim_now) + 1'b1) ?
							PosW'(count_q) + ((bad || count_q >= CntW'(MaxEntries)) ?
							PosW'(0) : PosW'(1)) : PosW'(mdim_now) + 1'b1;
					end
				end
				ST_SHIFT: begin
					if (!place_q && rd_greater) begin
						if (ptr_q == '0) place_q <= 1'b1;
						else ptr_q <= ptr_q - 1'b1;
					end else place_q <= 1'b0;
				end
				ST_EMIT_RD: ;
				ST_EMIT: begin
					res_q.position <= pos_q;
					res_q.entry_present <= CntW'(pos_q) < count_q;
					res_q.major_index <= (CntW'(pos_q) < count_q) ? rdata.major : '0;
					res_q.minor_index <= (CntW'(pos_q) < count_q) ? rdata.minor : '0;
					res_q.sorted_value <= (CntW'(pos_q) < count_q) ? rdata.value : '0;
					res_q.pointer_present <= pos_q <= PosW'(mdim_q);
					res_q.pointer_value <= (pos_q <= PosW'(mdim_q)) ? acc_q + PosW'(hsum) : '0;
					res_q.run_last <= pos_q + 1'b1 == n_q;
					res_q.status <= err_q[1] ? StatusOverflow : (err_q[0] ? StatusRange : StatusOk);
					out_v_q <= 1'b1;
					acc_q <= acc_q + PosW'(hsum);
					pos_q <= pos_q + 1'b1;
					if (pos_q + 1'b1 == n_q) begin
						count_q <= '0; err_q <= '0;
						for (int i = 0; i <= MaxDim; i++) hist_q[i] <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(MaxEntries)) else $error("count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.data.run_last && out.ready |=> count_q == '0)
		else $error("batch state not cleared");
	assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.ready |=> out.valid) else $error("word dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SHIFT |-> we) else $error("shift without write");
endmodule
